FILE: rtl/vrm_pkg.sv
// Shared constants, codes and controller/datapath interface types for the region map.
package vrm_pkg;

	// Default sizing and window reset values.
	localparam int MAX_AREAS_DEF   = 32;
	localparam int PAGE_BITS_DEF   = 20;
	localparam int USER_LOW_RESET  = 1024;
	localparam int USER_HIGH_RESET = 786432;

	// Operation codes carried with each request.
	localparam logic [2:0] MODE_GAP    = 3'd0;
	localparam logic [2:0] MODE_MAP    = 3'd1;
	localparam logic [2:0] MODE_LOOKUP = 3'd2;
	localparam logic [2:0] MODE_REMOVE = 3'd3;
	localparam logic [2:0] MODE_EMPTY  = 3'd4;
	localparam logic [2:0] MODE_CLEAR  = 3'd5;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_GAP   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_UNMAPPED = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_LOW  = 1'b0;
	localparam logic CFG_HIGH = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_GAP_CHK,
		S_GAP_EV,
		S_GAP_FINAL,
		S_GAP_DONE,
		S_LK_CHK,
		S_LK_EV,
		S_EM_CHK,
		S_EM_EV,
		S_EM_TAIL,
		S_EM_COMMIT,
		S_FIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       gap_init;
		logic       rd_dec;
		logic       rd_inc;
		logic       gap_eval;
		logic       gap_final;
		logic       res_gap;
		logic       scan_init;
		logic       em_init;
		logic       em_step;
		logic       em_tail;
		logic       commit;
		logic       set_status;
		logic [1:0] status;
		logic       set_flag;
		logic       flag;
		logic       res_lookup;
		logic       clear_total;
		logic       out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] mode;
		logic       n_zero;
		logic       sp_zero;
		logic       win_bad;
		logic       idx_zero;
		logic       idx_end;
		logic       gap_hit;
		logic       gap_final_hit;
		logic       lk_hit;
		logic       em_wr;
		logic       em_last;
		logic       full;
		logic       ins_pend;
		logic       out_free;
	} sts_t;

endpackage

FILE: rtl/virtual_region_map.sv
// Top level of the region map: stream ports, field packing and the two halves.
// One request at a time. Clear, unused modes, zero page counts and rejected maps give a result
// without a table scan; lookup and empty query scan the table upwards; find gap scans it from
// the top down; map at a page and remove copy the table into the spare bank; map anywhere does
// a gap search, then the copy. The next request is taken in the cycle after the result loads,
// and a stalled result holds it off. Reset empties the table.
module virtual_region_map #(
	parameter int MAX_AREAS        = vrm_pkg::MAX_AREAS_DEF,
	parameter int PAGE_NUMBER_BITS = vrm_pkg::PAGE_BITS_DEF,
	parameter int IN_TDW  = ((3 * PAGE_NUMBER_BITS + 5 + 7) / 8) * 8,
	parameter int OUT_TDW = ((3 * PAGE_NUMBER_BITS + 7 + $clog2(MAX_AREAS) + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// start_page, page_count, offset_page, protection, shared
	input  logic [IN_TDW-1:0]           s_tdata,
	// mode
	input  logic [2:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// flag, area_first, area_last, area_offset, area_protection, area_shared, slot_index
	output logic [OUT_TDW-1:0]          m_tdata,
	// status
	output logic [1:0]                  m_tuser,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [PAGE_NUMBER_BITS:0]   cfg_data
);
	import vrm_pkg::*;

	localparam int PNB = PAGE_NUMBER_BITS;
	localparam int PW  = PNB + 1;
	localparam int AW  = $clog2(MAX_AREAS);
	localparam int OFW = 3 * PNB + 7 + AW;

	cmd_t           cmd;
	sts_t           sts;
	logic           flag;
	logic [PW-1:0]  area_first;
	logic [PW-1:0]  area_last;
	logic [PNB-1:0] area_offset;
	logic [2:0]     area_protection;
	logic           area_shared;
	logic [AW-1:0]  slot_index;
	logic [OFW-1:0] out_fields;

	assign cfg_ready = 1'b1;

	vrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vrm_dp #(
		.MAX_AREAS        (MAX_AREAS),
		.PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mode            (s_tuser),
		.start_page      (s_tdata[PNB-1:0]),
		.page_count      (s_tdata[PNB +: PW]),
		.offset_page     (s_tdata[PNB+PW +: PNB]),
		.protection      (s_tdata[2*PNB+PW +: 3]),
		.shared          (s_tdata[2*PNB+PW+3]),
		.m_tready        (m_tready),
		.m_tvalid        (m_tvalid),
		.status          (m_tuser),
		.flag            (flag),
		.area_first      (area_first),
		.area_last       (area_last),
		.area_offset     (area_offset),
		.area_protection (area_protection),
		.area_shared     (area_shared),
		.slot_index      (slot_index)
	);

	// Result fields packed from the lowest bit up, zero filled to whole bytes.
	assign out_fields = {slot_index, area_shared, area_protection, area_offset,
		area_last, area_first, flag};
	assign m_tdata = OUT_TDW'(out_fields);

endmodule

FILE: rtl/vrm_dp.sv
// Datapath of the region map: request registers, table memories, scan and copy logic.
module vrm_dp #(
	parameter int MAX_AREAS        = 32,
	parameter int PAGE_NUMBER_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vrm_pkg::cmd_t                 cmd,
	output vrm_pkg::sts_t                 sts,
	input  logic                          cfg_wr,
	input  logic                          cfg_index,
	input  logic [PAGE_NUMBER_BITS:0]     cfg_data,
	input  logic [2:0]                    mode,
	input  logic [PAGE_NUMBER_BITS-1:0]   start_page,
	input  logic [PAGE_NUMBER_BITS:0]     page_count,
	input  logic [PAGE_NUMBER_BITS-1:0]   offset_page,
	input  logic [2:0]                    protection,
	input  logic                          shared,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [1:0]                    status,
	output logic                          flag,
	output logic [PAGE_NUMBER_BITS:0]     area_first,
	output logic [PAGE_NUMBER_BITS:0]     area_last,
	output logic [PAGE_NUMBER_BITS-1:0]   area_offset,
	output logic [2:0]                    area_protection,
	output logic                          area_shared,
	output logic [$clog2(MAX_AREAS)-1:0]  slot_index
);
	import vrm_pkg::*;

	localparam int PNB = PAGE_NUMBER_BITS;
	localparam int PW  = PNB + 1;
	localparam int AW  = $clog2(MAX_AREAS);
	localparam int CW  = $clog2(MAX_AREAS + 1);
	localparam int EW  = 2 * PW + PNB + 4;

	// Request registers.
	logic [2:0]     mode_q;
	logic [PNB-1:0] sp_q;
	logic [PW-1:0]  n_q;
	logic [PNB-1:0] off_q;
	logic [2:0]     prot_q;
	logic           shr_q;
	logic [PW:0]    e_q;
	logic [PW-1:0]  base_q;
	logic [PW-1:0]  hi_q;

	// Scan and copy control.
	logic [CW-1:0]  idx_q;
	logic [CW-1:0]  k_q;
	logic           ph_q;
	logic           ins_q;
	logic           cut_q;
	logic [AW-1:0]  pos_q;
	logic           sel_q;
	logic [CW-1:0]  total_q;
	logic [PW-1:0]  low_q;
	logic [PW-1:0]  high_q;

	// Two table banks: the live one is read, the other receives the copy.
	logic [EW-1:0]  bank0 [MAX_AREAS];
	logic [EW-1:0]  bank1 [MAX_AREAS];
	logic [EW-1:0]  rd0_q;
	logic [EW-1:0]  rd1_q;

	// Result being built and the output register.
	logic [1:0]     res_status_q;
	logic           res_flag_q;
	logic [PW-1:0]  res_first_q;
	logic [PW-1:0]  res_last_q;
	logic [PNB-1:0] res_off_q;
	logic [2:0]     res_prot_q;
	logic           res_shr_q;
	logic [AW-1:0]  res_slot_q;

	logic [1:0]     out_status_q;
	logic           out_flag_q;
	logic [PW-1:0]  out_first_q;
	logic [PW-1:0]  out_last_q;
	logic [PNB-1:0] out_off_q;
	logic [2:0]     out_prot_q;
	logic           out_shr_q;
	logic [AW-1:0]  out_slot_q;
	logic           m_tvalid_q;

	logic [EW-1:0]  rd;
	logic [PW-1:0]  rd_st;
	logic [PW-1:0]  rd_en;
	logic [PNB-1:0] rd_of;
	logic [2:0]     rd_pr;
	logic           rd_sh;
	logic [PW:0]    gap_c;
	logic           gap_ge;
	logic [CW-1:0]  ra_full;
	logic [AW-1:0]  ra;
	logic           ovl;
	logic           pv;
	logic [PW-1:0]  p_st;
	logic [PW-1:0]  p_en;
	logic [PNB-1:0] p_of;
	logic [PW:0]    trim;
	logic           ins_now;
	logic           em_last;
	logic           wr_en;
	logic [EW-1:0]  wd;
	logic [EW-1:0]  new_ent;
	logic           cut_new;
	logic [PW-1:0]  base_src;
	logic [CW-1:0]  idx_prev;

	// Entry fields of the last read.
	assign rd    = sel_q ? rd1_q : rd0_q;
	assign rd_st = rd[EW-1 -: PW];
	assign rd_en = rd[EW-1-PW -: PW];
	assign rd_of = rd[PNB+3:4];
	assign rd_pr = rd[3:1];
	assign rd_sh = rd[0];

	assign new_ent  = {base_q, e_q[PW-1:0], off_q, prot_q, shr_q};
	assign idx_prev = idx_q - 1'b1;
	assign ra_full  = cmd.rd_dec ? idx_prev : idx_q;
	assign ra       = ra_full[AW-1:0];

	// Gap candidate just below the running upper bound.
	assign gap_ge = hi_q >= n_q;
	assign gap_c  = {1'b0, hi_q} - {1'b0, n_q};

	// Pieces of the current entry when copying with a cut and an insertion.
	assign ovl  = cut_q && !(rd_en <= base_q || {1'b0, rd_st} >= e_q);
	assign trim = e_q - {1'b0, rd_st};
	always_comb begin
		if (!ph_q) begin
			pv   = !ovl || (rd_st < base_q);
			p_st = rd_st;
			p_en = ovl ? base_q : rd_en;
			p_of = rd_of;
		end else begin
			pv   = {1'b0, rd_en} > e_q;
			p_st = e_q[PW-1:0];
			p_en = rd_en;
			p_of = rd_of + trim[PNB-1:0];
		end
	end
	assign ins_now = ins_q && pv && ({1'b0, p_st} >= e_q);
	assign em_last = !ins_now && (ph_q || !ovl);

	assign wr_en = (cmd.em_step && pv) || cmd.em_tail;
	assign wd    = (cmd.em_tail || ins_now) ? new_ent : {p_st, p_en, p_of, rd_pr, rd_sh};

	assign cut_new  = !(mode_q == MODE_MAP && sp_q == '0);
	assign base_src = cut_new ? {1'b0, sp_q} : base_q;

	// Status towards the controller.
	always_comb begin
		sts.mode          = mode_q;
		sts.n_zero        = n_q == '0;
		sts.sp_zero       = sp_q == '0;
		sts.win_bad       = ({1'b0, sp_q} < low_q) || (e_q > {1'b0, high_q});
		sts.idx_zero      = idx_q == '0;
		sts.idx_end       = idx_q >= total_q;
		sts.gap_hit       = gap_ge && gap_c[PW-1:0] >= rd_en && gap_c[PW-1:0] >= low_q;
		sts.gap_final_hit = gap_ge && gap_c[PW-1:0] >= low_q;
		sts.lk_hit        = (mode_q == MODE_LOOKUP) ?
			({1'b0, sp_q} >= rd_st && {1'b0, sp_q} < rd_en) :
			(rd_en > {1'b0, sp_q} && {1'b0, rd_st} < e_q);
		sts.em_wr         = pv;
		sts.em_last       = em_last;
		sts.full          = k_q == CW'(MAX_AREAS);
		sts.ins_pend      = ins_q;
		sts.out_free      = !m_tvalid_q || m_tready;
	end

	// Table memories: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (sel_q) bank0[k_q[AW-1:0]] <= wd;
			else       bank1[k_q[AW-1:0]] <= wd;
		end
		if (cmd.rd_dec || cmd.rd_inc) begin
			rd0_q <= bank0[ra];
			rd1_q <= bank1[ra];
		end
	end

	// Control state: configuration, bank select, entry count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q      <= PW'(USER_LOW_RESET);
			high_q     <= PW'(USER_HIGH_RESET);
			sel_q      <= 1'b0;
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (cfg_index == CFG_LOW) low_q <= cfg_data;
				else                      high_q <= cfg_data;
			end
			if (cmd.commit) begin
				sel_q   <= ~sel_q;
				total_q <= k_q;
			end
			if (cmd.clear_total) total_q <= '0;
			if (cmd.out_load)    m_tvalid_q <= 1'b1;
			else if (m_tready)   m_tvalid_q <= 1'b0;
		end
	end

	// Request, scan and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q       <= mode;
			sp_q         <= start_page;
			n_q          <= page_count;
			off_q        <= offset_page;
			prot_q       <= protection;
			shr_q        <= shared;
			e_q          <= {2'b00, start_page} + {1'b0, page_count};
			res_status_q <= ST_OK;
			res_flag_q   <= 1'b0;
			res_first_q  <= '0;
			res_last_q   <= '0;
			res_off_q    <= '0;
			res_prot_q   <= '0;
			res_shr_q    <= 1'b0;
			res_slot_q   <= '0;
		end
		if (cmd.gap_init) begin
			hi_q  <= high_q;
			idx_q <= total_q;
		end
		if (cmd.rd_dec) idx_q <= idx_prev;
		if (cmd.rd_inc) begin
			idx_q <= idx_q + 1'b1;
			ph_q  <= 1'b0;
		end
		if (cmd.gap_eval) begin
			if (sts.gap_hit)      base_q <= gap_c[PW-1:0];
			else if (rd_st < hi_q) hi_q  <= rd_st;
		end
		if (cmd.gap_final) base_q <= gap_c[PW-1:0];
		if (cmd.res_gap) begin
			res_first_q <= base_q;
			res_last_q  <= base_q + n_q;
		end
		if (cmd.scan_init) idx_q <= '0;
		if (cmd.em_init) begin
			base_q <= base_src;
			e_q    <= {1'b0, base_src} + {1'b0, n_q};
			cut_q  <= cut_new;
			ins_q  <= mode_q == MODE_MAP;
			k_q    <= '0;
			idx_q  <= '0;
		end
		if (cmd.em_step) begin
			if (ins_now) begin
				pos_q <= k_q[AW-1:0];
				ins_q <= 1'b0;
			end else begin
				ph_q <= !em_last;
			end
			if (pv) k_q <= k_q + 1'b1;
		end
		if (cmd.em_tail) begin
			pos_q <= k_q[AW-1:0];
			ins_q <= 1'b0;
			k_q   <= k_q + 1'b1;
		end
		if (cmd.commit && mode_q == MODE_MAP) begin
			res_first_q <= base_q;
			res_last_q  <= e_q[PW-1:0];
			res_off_q   <= off_q;
			res_prot_q  <= prot_q;
			res_shr_q   <= shr_q;
			res_slot_q  <= pos_q;
		end
		if (cmd.set_status) res_status_q <= cmd.status;
		if (cmd.set_flag)   res_flag_q <= cmd.flag;
		if (cmd.res_lookup) begin
			res_flag_q  <= 1'b1;
			res_first_q <= rd_st;
			res_last_q  <= rd_en;
			res_off_q   <= rd_of;
			res_prot_q  <= rd_pr;
			res_shr_q   <= rd_sh;
			res_slot_q  <= idx_prev[AW-1:0];
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_flag_q   <= res_flag_q;
			out_first_q  <= res_first_q;
			out_last_q   <= res_last_q;
			out_off_q    <= res_off_q;
			out_prot_q   <= res_prot_q;
			out_shr_q    <= res_shr_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign m_tvalid        = m_tvalid_q;
	assign status          = out_status_q;
	assign flag            = out_flag_q;
	assign area_first      = out_first_q;
	assign area_last       = out_last_q;
	assign area_offset     = out_off_q;
	assign area_protection = out_prot_q;
	assign area_shared     = out_shr_q;
	assign slot_index      = out_slot_q;

endmodule

FILE: rtl/vrm_ctrl.sv
// Controller state machine of the region map: sequences scans, copies and results.
module vrm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  vrm_pkg::sts_t sts,
	output vrm_pkg::cmd_t cmd
);
	import vrm_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FIN;
				case (sts.mode)
					MODE_GAP: begin
						if (sts.n_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_NO_GAP;
						end else begin
							cmd.gap_init = 1'b1;
							state_d      = S_GAP_CHK;
						end
					end
					MODE_MAP: begin
						if (sts.n_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_NO_GAP;
						end else if (sts.sp_zero) begin
							cmd.gap_init = 1'b1;
							state_d      = S_GAP_CHK;
						end else if (sts.win_bad) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_NO_GAP;
						end else begin
							cmd.em_init = 1'b1;
							state_d     = S_EM_CHK;
						end
					end
					MODE_LOOKUP: begin
						cmd.scan_init = 1'b1;
						state_d       = S_LK_CHK;
					end
					MODE_REMOVE: begin
						if (!sts.n_zero) begin
							cmd.em_init = 1'b1;
							state_d     = S_EM_CHK;
						end
					end
					MODE_EMPTY: begin
						if (sts.n_zero) begin
							cmd.set_flag = 1'b1;
							cmd.flag     = 1'b1;
						end else begin
							cmd.scan_init = 1'b1;
							state_d       = S_LK_CHK;
						end
					end
					MODE_CLEAR: cmd.clear_total = 1'b1;
					default: state_d = S_FIN;
				endcase
			end
			// Gap search walks the table from the top entry down.
			S_GAP_CHK: begin
				if (sts.idx_zero) begin
					state_d = S_GAP_FINAL;
				end else begin
					cmd.rd_dec = 1'b1;
					state_d    = S_GAP_EV;
				end
			end
			S_GAP_EV: begin
				cmd.gap_eval = 1'b1;
				state_d      = sts.gap_hit ? S_GAP_DONE : S_GAP_CHK;
			end
			S_GAP_FINAL: begin
				if (sts.gap_final_hit) begin
					cmd.gap_final = 1'b1;
					state_d       = S_GAP_DONE;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NO_GAP;
					state_d        = S_FIN;
				end
			end
			S_GAP_DONE: begin
				if (sts.mode == MODE_GAP) begin
					cmd.res_gap = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.em_init = 1'b1;
					state_d     = S_EM_CHK;
				end
			end
			// Lookup and empty query walk the table upwards.
			S_LK_CHK: begin
				if (sts.idx_end) begin
					if (sts.mode == MODE_LOOKUP) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_UNMAPPED;
					end else begin
						cmd.set_flag = 1'b1;
						cmd.flag     = 1'b1;
					end
					state_d = S_FIN;
				end else begin
					cmd.rd_inc = 1'b1;
					state_d    = S_LK_EV;
				end
			end
			S_LK_EV: begin
				if (sts.lk_hit) begin
					if (sts.mode == MODE_LOOKUP) begin
						cmd.res_lookup = 1'b1;
					end else begin
						cmd.set_flag = 1'b1;
						cmd.flag     = 1'b0;
					end
					state_d = S_FIN;
				end else begin
					state_d = S_LK_CHK;
				end
			end
			// Copy into the spare bank, cutting and inserting on the way.
			S_EM_CHK: begin
				if (sts.idx_end) begin
					state_d = S_EM_TAIL;
				end else begin
					cmd.rd_inc = 1'b1;
					state_d    = S_EM_EV;
				end
			end
			S_EM_EV: begin
				if (sts.em_wr && sts.full) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_FULL;
					state_d        = S_FIN;
				end else begin
					cmd.em_step = 1'b1;
					if (sts.em_last) state_d = S_EM_CHK;
				end
			end
			S_EM_TAIL: begin
				if (sts.ins_pend && sts.full) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_FULL;
					state_d        = S_FIN;
				end else begin
					cmd.em_tail = sts.ins_pend;
					state_d     = S_EM_COMMIT;
				end
			end
			S_EM_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: dv/vrm_checker.sv
// Checker for the region map: watches all three channels, predicts each result and compares it.
module vrm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [20:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	import vrm_pkg::*;

	localparam int     TABLE_DEPTH = 32;
	localparam longint MASK20      = 64'hFFFFF;
	localparam longint MASK21      = 64'h1FFFFF;

	typedef struct {
		longint first;
		longint last;
		longint ofs;
		longint prot;
		longint shr;
	} region_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        flag;
		logic [20:0] first;
		logic [20:0] last;
		logic [19:0] ofs;
		logic [2:0]  prot;
		logic        shr;
		logic [4:0]  slot;
	} outcome_t;

	region_t  regions[$];
	region_t  scratch[$];
	longint   win_low;
	longint   win_high;
	outcome_t expected_q[$];

	// Append one entry to the scratch table; returns 0 when the table would overflow.
	function automatic bit scratch_push(longint f, longint l, longint o, longint p, longint sh);
		region_t r;
		if (scratch.size() >= TABLE_DEPTH)
			return 0;
		r.first = f & MASK21;
		r.last  = l & MASK21;
		r.ofs   = o & MASK20;
		r.prot  = p;
		r.shr   = sh;
		scratch.push_back(r);
		return 1;
	endfunction

	// Build the scratch table from the live one without the pages in [s, e).
	function automatic bit carve(longint s, longint e);
		scratch = {};
		foreach (regions[i]) begin
			if (regions[i].last <= s || regions[i].first >= e) begin
				if (!scratch_push(regions[i].first, regions[i].last, regions[i].ofs,
						regions[i].prot, regions[i].shr))
					return 0;
			end else begin
				if (regions[i].first < s && !scratch_push(regions[i].first, s, regions[i].ofs,
						regions[i].prot, regions[i].shr))
					return 0;
				if (regions[i].last > e && !scratch_push(e, regions[i].last,
						regions[i].ofs + (e - regions[i].first), regions[i].prot,
						regions[i].shr))
					return 0;
			end
		end
		return 1;
	endfunction

	// Highest free gap of n pages, searched top down; -1 when none exists.
	function automatic longint highest_gap(longint n);
		longint hi;
		longint c;
		hi = win_high;
		for (int i = regions.size() - 1; i >= 0; i--) begin
			if (hi >= n) begin
				c = hi - n;
				if (c >= regions[i].last && c >= win_low)
					return c;
			end
			if (regions[i].first < hi)
				hi = regions[i].first;
		end
		if (hi >= n && hi - n >= win_low)
			return hi - n;
		return -1;
	endfunction

	// Apply one request to the table copy and return the result it produces.
	function automatic outcome_t apply_request(logic [2:0] mode, longint sp, longint n,
			longint off, longint prot, longint shr);
		outcome_t r;
		longint   base;
		longint   g;
		int       pos;
		region_t  fresh;
		r = '0;
		case (mode)
			MODE_GAP: begin
				g = (n == 0) ? -1 : highest_gap(n);
				if (g < 0) begin
					r.status = ST_NO_GAP;
				end else begin
					r.first = 21'(g);
					r.last  = 21'(g + n);
				end
			end
			MODE_MAP: begin
				if (n == 0) begin
					r.status = ST_NO_GAP;
					return r;
				end
				if (sp == 0) begin
					g = highest_gap(n);
					if (g < 0) begin
						r.status = ST_NO_GAP;
						return r;
					end
					base    = g;
					scratch = regions;
				end else begin
					if (sp < win_low || sp + n > win_high) begin
						r.status = ST_NO_GAP;
						return r;
					end
					base = sp;
					if (!carve(sp, sp + n)) begin
						r.status = ST_FULL;
						return r;
					end
				end
				if (scratch.size() >= TABLE_DEPTH) begin
					r.status = ST_FULL;
					return r;
				end
				pos = 0;
				while (pos < scratch.size() && scratch[pos].first < base + n)
					pos++;
				fresh.first = base & MASK21;
				fresh.last  = (base + n) & MASK21;
				fresh.ofs   = off;
				fresh.prot  = prot;
				fresh.shr   = shr;
				scratch.insert(pos, fresh);
				regions = scratch;
				r.first = 21'(fresh.first);
				r.last  = 21'(fresh.last);
				r.ofs   = 20'(off);
				r.prot  = 3'(prot);
				r.shr   = 1'(shr);
				r.slot  = 5'(pos);
			end
			MODE_LOOKUP: begin
				r.status = ST_UNMAPPED;
				foreach (regions[i]) begin
					if (sp >= regions[i].first && sp < regions[i].last) begin
						r.status = ST_OK;
						r.flag   = 1'b1;
						r.first  = 21'(regions[i].first);
						r.last   = 21'(regions[i].last);
						r.ofs    = 20'(regions[i].ofs);
						r.prot   = 3'(regions[i].prot);
						r.shr    = 1'(regions[i].shr);
						r.slot   = 5'(i);
						break;
					end
				end
			end
			MODE_REMOVE: begin
				if (n != 0) begin
					if (carve(sp, sp + n))
						regions = scratch;
					else
						r.status = ST_FULL;
				end
			end
			MODE_EMPTY: begin
				r.flag = 1'b1;
				if (n != 0) begin
					foreach (regions[i]) begin
						if (regions[i].last > sp && regions[i].first < sp + n) begin
							r.flag = 1'b0;
							break;
						end
					end
				end
			end
			MODE_CLEAR: regions = {};
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic check_field(string what, longint got, longint want);
		if (got != want)
			report(what, got, want);
	endtask

	// Follow configuration writes, requests and results on every rising edge.
	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			regions    = {};
			expected_q = {};
			win_low    = USER_LOW_RESET;
			win_high   = USER_HIGH_RESET;
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_LOW)
					win_low = longint'(cfg_data);
				else
					win_high = longint'(cfg_data);
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(apply_request(s_tuser, s_tdata[19:0], s_tdata[40:20],
					s_tdata[60:41], s_tdata[63:61], s_tdata[64]));
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.flag   = m_tdata[0];
				got.first  = m_tdata[21:1];
				got.last   = m_tdata[42:22];
				got.ofs    = m_tdata[62:43];
				got.prot   = m_tdata[65:63];
				got.shr    = m_tdata[66];
				got.slot   = m_tdata[71:67];
				if (expected_q.size() == 0) begin
					report("unexpected result", 1, 0);
				end else begin
					want = expected_q.pop_front();
					check_field("status", got.status, want.status);
					check_field("flag", got.flag, want.flag);
					check_field("area_first", got.first, want.first);
					check_field("area_last", got.last, want.last);
					check_field("area_offset", got.ofs, want.ofs);
					check_field("area_protection", got.prot, want.prot);
					check_field("area_shared", got.shr, want.shr);
					check_field("slot_index", got.slot, want.slot);
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

FILE: dv/tb_virtual_region_map.sv
// Testbench top for the region map: clock, reset, request stimulus and the verdict.
module tb_virtual_region_map;
	import vrm_pkg::*;

	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;
	localparam int         SETTLE       = 120;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [20:0] cfg_data;
	int          fail_count;
	int          pending;
	int          burst_left;
	longint      span_low;
	longint      span_high;

	virtual_region_map dut (.*);

	vrm_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver back-pressure: the stall pattern moves through four phases in turn.
	always @(negedge clk) begin
		int phase;
		phase = int'(($time / 2000) % 4);
		case (phase)
			0: m_tready = 1'b1;
			1: m_tready = 1'($urandom_range(0, 1));
			2: m_tready = ($urandom_range(0, 3) == 0);
			default: m_tready = ($urandom_range(0, 19) != 0) ? m_tready : ~m_tready;
		endcase
	end

	// Send one request; the sender pauses between bursts of random length.
	task automatic send(logic [2:0] mode, longint sp, longint n, longint off,
			logic [2:0] prot, logic shr);
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid = 1'b1;
		s_tuser  = mode;
		s_tdata  = {7'b0, shr, prot, off[19:0], n[20:0], sp[19:0]};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Window writes happen only with the block idle.
	task automatic set_window(longint low, longint high);
		s_tvalid = 1'b0;
		wait (pending == 0);
		repeat (SETTLE) @(negedge clk);
		for (int k = 0; k < 2; k++) begin
			cfg_valid = 1'b1;
			cfg_index = (k == 0) ? CFG_LOW : CFG_HIGH;
			cfg_data  = 21'((k == 0) ? low : high);
			do
				@(posedge clk);
			while (!cfg_ready);
			@(negedge clk);
			cfg_valid = 1'b0;
		end
		span_low  = low;
		span_high = high;
	endtask

	// One random request, mostly aimed at pages inside the current window.
	task automatic random_request();
		int     pick;
		longint span;
		longint sp;
		longint n;
		logic [2:0] mode;
		span = (span_high > span_low) ? span_high - span_low : 64;
		pick = $urandom_range(0, 99);
		if (pick < 38)
			mode = MODE_MAP;
		else if (pick < 53)
			mode = MODE_LOOKUP;
		else if (pick < 70)
			mode = MODE_REMOVE;
		else if (pick < 82)
			mode = MODE_GAP;
		else if (pick < 94)
			mode = MODE_EMPTY;
		else if (pick < 97)
			mode = MODE_CLEAR;
		else
			mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
		sp = (span_low + $urandom_range(0, span)) & 64'hFFFFF;
		if ($urandom_range(0, 19) == 0)
			sp = $urandom_range(0, 20'hFFFFF);
		if (mode == MODE_MAP && $urandom_range(0, 4) == 0)
			sp = 0;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			n = $urandom_range(1, span / 6 + 1);
		else if (pick < 93)
			n = $urandom_range(0, 21'h1FFFFF);
		else if (pick < 97)
			n = 0;
		else
			n = 21'h100000;
		send(mode, sp, n, $urandom_range(0, 20'hFFFFF), 3'($urandom_range(0, 7)),
			1'($urandom_range(0, 1)));
	endtask

	// Run limit.
	initial begin
		#30000000;
		$display("tb_virtual_region_map failed");
		$finish;
	end

	initial begin
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = MODE_GAP;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_LOW;
		cfg_data   = '0;
		m_tready   = 1'b0;
		burst_left = 0;
		span_low   = USER_LOW_RESET;
		span_high  = USER_HIGH_RESET;
		arst_n     = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset window, empty table, extremes and corner cases.
		send(MODE_GAP, 0, 1, 0, 0, 0);
		send(MODE_GAP, 0, 0, 0, 0, 0);
		send(MODE_GAP, 0, 21'h100000, 0, 0, 0);
		send(MODE_MAP, 1024, 16, 20'hFFFFF, 3'd7, 1'b1);
		send(MODE_MAP, 0, 8, 20'h12345, 3'd5, 1'b0);
		send(MODE_MAP, 786400, 32, 1, 3'd1, 1'b1);
		send(MODE_MAP, 786420, 32, 1, 3'd1, 1'b1);
		send(MODE_MAP, 1000, 4, 0, 0, 0);
		send(MODE_MAP, 2000, 0, 0, 0, 0);
		send(MODE_LOOKUP, 1030, 0, 0, 0, 0);
		send(MODE_LOOKUP, 5000, 0, 0, 0, 0);
		send(MODE_LOOKUP, 20'hFFFFF, 0, 0, 0, 0);
		// Trim the front of the wrapping offset, then split an entry.
		send(MODE_REMOVE, 1024, 2, 0, 0, 0);
		send(MODE_LOOKUP, 1026, 0, 0, 0, 0);
		send(MODE_REMOVE, 1030, 3, 0, 0, 0);
		send(MODE_REMOVE, 1030, 0, 0, 0, 0);
		send(MODE_EMPTY, 1030, 3, 0, 0, 0);
		send(MODE_EMPTY, 1020, 10, 0, 0, 0);
		send(MODE_EMPTY, 1026, 0, 0, 0, 0);
		send(MODE_MAP, 1028, 4, 7, 3'd2, 1'b0);
		send(MODE_SPARE_A, 20'hFFFFF, 21'h1FFFFF, 20'hFFFFF, 3'd7, 1'b1);
		send(MODE_SPARE_B, 0, 0, 0, 0, 0);
		send(MODE_CLEAR, 0, 0, 0, 0, 0);
		send(MODE_LOOKUP, 1026, 0, 0, 0, 0);

		// Random phases over several windows, small ones to crowd the table.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_window(1024, 1024 + 2048);
				1: set_window(0, 21'h100000);
				2: set_window(4096, 4096 + 256);
				3: set_window(21'h100000, 21'h100000);
				4: set_window(500, 200);
				5: set_window(1, 300);
				default: set_window(21'h0FFF00, 21'h100000);
			endcase
			repeat (150) random_request();
		end
		set_window(USER_LOW_RESET, USER_HIGH_RESET);
		repeat (10) random_request();

		s_tvalid = 1'b0;
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("tb_virtual_region_map passed");
		else
			$display("tb_virtual_region_map failed");
		$finish;
	end

endmodule
